[sv/assert_macros.svh]
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is off while reset is high
`define SEM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SEM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/sem_pkg.sv]
// shared types and constants of the rgb sobel edge magnitude block
// no dependencies
`default_nettype none

package sem_pkg;

   localparam int PIX_W    = 8;
   localparam int NUM_CH   = 3;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 12;
   localparam int CFG_W_W  = 11;
   localparam int CFG_H_W  = 12;
   localparam int SUM_W    = 22;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   // request kinds carried in tuser
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   // square sums at or above this give the clamped magnitude
   localparam logic [SUM_W-1:0] ROOT_SAT = 22'd65281;
   localparam logic [PIX_W-1:0] MAG_MAX  = 8'd255;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic latch;
      logic mul;
      logic read;
      logic shift;
      logic real_px;
      logic grad;
      logic sqr;
      logic root;
      logic emit;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic in_done;
      logic arrivals_zero;
      logic emit_ok;
      logic flush_more;
      logic root_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[sv/sem_ctrl.sv]
// controller state machine of the sobel edge block
// depends on sem_pkg for command and status types
`default_nettype none

module sem_ctrl
   import sem_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_func,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LATCH,
      ST_MUL,
      ST_READ,
      ST_SHIFT,
      ST_FCHECK,
      ST_GRAD,
      ST_SQR,
      ST_ROOT,
      ST_ROUND
   } state_type;

   state_type state_ff;
   logic      flush_ff;
   logic      final_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // commands decoded from the state
   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      cmd.real_px = !flush_ff;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_LATCH:  cmd.latch = 1'b1;
         ST_MUL:    cmd.mul   = 1'b1;
         ST_READ:   cmd.read  = 1'b1;
         ST_SHIFT:  cmd.shift = 1'b1;
         ST_GRAD:   cmd.grad  = 1'b1;
         ST_SQR:    cmd.sqr   = 1'b1;
         ST_ROOT:   cmd.root  = 1'b1;
         ST_ROUND:  cmd.emit  = status.out_free;
         default:   cmd.clear = 1'b0;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         flush_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  flush_ff <= req_func;
                  final_ff <= 1'b0;
                  if (req_func == FUNC_PIXEL) begin
                     if (status.in_done)            state_ff <= ST_IDLE;
                     else if (status.arrivals_zero) state_ff <= ST_LATCH;
                     else                           state_ff <= ST_READ;
                  end else begin
                     if (status.in_done) state_ff <= ST_FCHECK;
                     else                state_ff <= ST_IDLE;
                  end
               end
            end
            ST_LATCH:  state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_READ;
            ST_READ:   state_ff <= ST_SHIFT;
            ST_SHIFT: begin
               if (!flush_ff) state_ff <= status.emit_ok ? ST_GRAD : ST_IDLE;
               else           state_ff <= final_ff ? ST_GRAD : ST_FCHECK;
            end
            ST_FCHECK: begin
               if (!status.flush_more) final_ff <= 1'b1;
               state_ff <= ST_READ;
            end
            ST_GRAD:   state_ff <= ST_SQR;
            ST_SQR:    state_ff <= ST_ROOT;
            ST_ROOT: begin
               if (status.root_last) state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default:   state_ff <= ST_CLEAR;
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/sem_datapath.sv]
// datapath: line stores, window, counters, gradients, root and result register
// depends on sem_pkg for types and constants
`default_nettype none

module sem_datapath
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_cmd_type              cmd,
   output dp_status_type                  status,
   input  wire logic [NUM_CH*PIX_W-1:0]   req_pixel,
   input  wire logic                      csr_write,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [NUM_CH*PIX_W-1:0]        rsp_pixel,
   output logic                           rsp_last
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int GWW = $clog2(MAX_WIDTH + 1);
   localparam int GHW = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW  = $clog2(MAX_WIDTH * (MAX_HEIGHT + 1) + 2);
   localparam int DW  = NUM_CH * PIX_W;
   localparam int GW  = 12;

   // configuration registers
   logic [CFG_W_W-1:0] csr_width_ff;
   logic [CFG_H_W-1:0] csr_height_ff;

   // frame geometry and counters
   logic [GWW-1:0] geo_w_ff;
   logic [GHW-1:0] geo_h_ff;
   logic [CW-1:0]  total_ff;
   logic [CW-1:0]  arrivals_ff;
   logic [CW-1:0]  out_count_ff;
   logic [AW-1:0]  in_col_ff;
   logic [AW-1:0]  out_col_ff;
   logic [RW-1:0]  out_row_ff;
   logic           in_done_ff;
   logic [AW-1:0]  clr_addr_ff;

   // line stores and window
   logic [DW-1:0] upper_mem [MAX_WIDTH];
   logic [DW-1:0] lower_mem [MAX_WIDTH];
   logic [DW-1:0] top_rd_ff;
   logic [DW-1:0] mid_rd_ff;
   logic [DW-1:0] pix_ff;
   logic [DW-1:0] win_ff [3][3];

   // arithmetic stages
   logic signed [GW-1:0] gx_ff [NUM_CH];
   logic signed [GW-1:0] gy_ff [NUM_CH];
   logic [SUM_W-1:0]     sum_ff [NUM_CH];
   logic [PIX_W-1:0]     q_ff [NUM_CH];
   logic [2:0]           bit_ff;

   logic [DW-1:0]  rsp_pixel_ff;
   logic           rsp_valid_ff;
   logic           rsp_last_ff;

   logic [31:0]    clamp_w32;
   logic [31:0]    clamp_h32;
   logic           top_ok, bot_ok, left_ok, right_ok;
   logic           frame_last;
   logic [DW-1:0]  pm [3][3];
   logic signed [GW-1:0] gx_c [NUM_CH];
   logic signed [GW-1:0] gy_c [NUM_CH];
   logic [SUM_W-1:0]     sum_c [NUM_CH];
   logic [PIX_W-1:0]     q_c [NUM_CH];
   logic [PIX_W-1:0]     mag_c [NUM_CH];

   // geometry clamp of the register values
   always_comb begin
      clamp_w32 = 32'(csr_width_ff);
      if (clamp_w32 == 32'd0)                 clamp_w32 = 32'd1;
      else if (clamp_w32 > 32'(MAX_WIDTH))    clamp_w32 = 32'(MAX_WIDTH);
      clamp_h32 = 32'(csr_height_ff);
      if (clamp_h32 == 32'd0)                 clamp_h32 = 32'd1;
      else if (clamp_h32 > 32'(MAX_HEIGHT))   clamp_h32 = 32'(MAX_HEIGHT);
   end

   // border masks of the output position
   assign top_ok     = (out_row_ff != '0);
   assign bot_ok     = (GHW'(out_row_ff) != geo_h_ff - GHW'(1));
   assign left_ok    = (out_col_ff != '0);
   assign right_ok   = (GWW'(out_col_ff) != geo_w_ff - GWW'(1));
   assign frame_last = !bot_ok && !right_ok;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pm[i][j] = win_ff[i][j];
            if ((i == 0 && !top_ok) || (i == 2 && !bot_ok) ||
                (j == 0 && !left_ok) || (j == 2 && !right_ok)) begin
               pm[i][j] = '0;
            end
         end
      end
   end

   // per channel gradients, square sums and root steps
   always_comb begin
      logic [9:0]  px, nx, py, ny;
      logic [23:0] sqx, sqy;
      logic [PIX_W-1:0] t;
      logic [15:0] tt;
      logic [16:0] qq;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         px = 10'(pm[0][2][ch*PIX_W +: PIX_W]) + {1'b0, pm[1][2][ch*PIX_W +: PIX_W], 1'b0}
            + 10'(pm[2][2][ch*PIX_W +: PIX_W]);
         nx = 10'(pm[0][0][ch*PIX_W +: PIX_W]) + {1'b0, pm[1][0][ch*PIX_W +: PIX_W], 1'b0}
            + 10'(pm[2][0][ch*PIX_W +: PIX_W]);
         py = 10'(pm[2][0][ch*PIX_W +: PIX_W]) + {1'b0, pm[2][1][ch*PIX_W +: PIX_W], 1'b0}
            + 10'(pm[2][2][ch*PIX_W +: PIX_W]);
         ny = 10'(pm[0][0][ch*PIX_W +: PIX_W]) + {1'b0, pm[0][1][ch*PIX_W +: PIX_W], 1'b0}
            + 10'(pm[0][2][ch*PIX_W +: PIX_W]);
         gx_c[ch] = $signed({2'b00, px}) - $signed({2'b00, nx});
         gy_c[ch] = $signed({2'b00, py}) - $signed({2'b00, ny});
         sqx = 24'(gx_ff[ch] * gx_ff[ch]);
         sqy = 24'(gy_ff[ch] * gy_ff[ch]);
         sum_c[ch] = SUM_W'(sqx) + SUM_W'(sqy);
         // one result bit a cycle
         t  = q_ff[ch] | (PIX_W'(1) << bit_ff);
         tt = 16'(t) * 16'(t);
         q_c[ch] = (SUM_W'(tt) <= sum_ff[ch]) ? t : q_ff[ch];
         // round to nearest and clamp
         qq = 17'(q_ff[ch]) * 17'(q_ff[ch]) + 17'(q_ff[ch]);
         if (sum_ff[ch] >= ROOT_SAT)        mag_c[ch] = MAG_MAX;
         else if (SUM_W'(qq) < sum_ff[ch])  mag_c[ch] = q_ff[ch] + PIX_W'(1);
         else                               mag_c[ch] = q_ff[ch];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= 11'd640;
         csr_height_ff <= 12'd480;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  csr_width_ff  <= csr_data[CFG_W_W-1:0];
            REG_FRAME_HEIGHT: csr_height_ff <= csr_data[CFG_H_W-1:0];
            default: ;
         endcase
      end
   end

   // line stores with registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         upper_mem[clr_addr_ff] <= '0;
         lower_mem[clr_addr_ff] <= '0;
      end else if (cmd.shift && cmd.real_px) begin
         upper_mem[in_col_ff] <= mid_rd_ff;
         lower_mem[in_col_ff] <= pix_ff;
      end
      if (cmd.read) begin
         top_rd_ff <= upper_mem[in_col_ff];
         mid_rd_ff <= lower_mem[in_col_ff];
      end
   end

   // captured pixel, geometry and arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.capture) pix_ff <= req_pixel;
      if (cmd.latch) begin
         geo_w_ff <= GWW'(clamp_w32);
         geo_h_ff <= GHW'(clamp_h32);
      end
      if (cmd.mul) total_ff <= CW'(CW'(geo_w_ff) * CW'(geo_h_ff));
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (cmd.grad) begin
            gx_ff[ch] <= gx_c[ch];
            gy_ff[ch] <= gy_c[ch];
         end
         if (cmd.sqr) begin
            sum_ff[ch] <= sum_c[ch];
            q_ff[ch]   <= '0;
         end else if (cmd.root) begin
            q_ff[ch]   <= q_c[ch];
         end
      end
      if (cmd.sqr)       bit_ff <= 3'd7;
      else if (cmd.root) bit_ff <= bit_ff - 3'd1;
      if (cmd.emit) begin
         for (int ch = 0; ch < NUM_CH; ch++) rsp_pixel_ff[ch*PIX_W +: PIX_W] <= mag_c[ch];
         rsp_last_ff <= frame_last;
      end
   end

   // window, counters and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win_ff[i][j] <= '0;
         arrivals_ff  <= '0;
         out_count_ff <= '0;
         in_col_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         in_done_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.latch) begin
            in_col_ff    <= '0;
            out_count_ff <= '0;
            out_col_ff   <= '0;
            out_row_ff   <= '0;
         end
         if (cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= top_rd_ff;
            win_ff[1][2] <= mid_rd_ff;
            win_ff[2][2] <= cmd.real_px ? pix_ff : '0;
            arrivals_ff  <= arrivals_ff + CW'(1);
            if (GWW'(in_col_ff) + GWW'(1) >= geo_w_ff) in_col_ff <= '0;
            else                                       in_col_ff <= in_col_ff + AW'(1);
            if (cmd.real_px && (arrivals_ff + CW'(1) >= total_ff)) in_done_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            if (frame_last) begin
               out_count_ff <= '0;
               arrivals_ff  <= '0;
               in_col_ff    <= '0;
               out_col_ff   <= '0;
               out_row_ff   <= '0;
               in_done_ff   <= 1'b0;
            end else begin
               out_count_ff <= out_count_ff + CW'(1);
               if (!right_ok) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + RW'(1);
               end else begin
                  out_col_ff <= out_col_ff + AW'(1);
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status to the controller
   always_comb begin
      status.clear_last    = (clr_addr_ff == AW'(MAX_WIDTH - 1));
      status.in_done       = in_done_ff;
      status.arrivals_zero = (arrivals_ff == '0);
      status.emit_ok       = (arrivals_ff >= CW'(geo_w_ff) + CW'(1));
      status.flush_more    = (arrivals_ff < out_count_ff + CW'(geo_w_ff) + CW'(1));
      status.root_last     = (bit_ff == 3'd0);
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

[sv/sobel_edge_magnitude_rgb_top.sv]
// top level of the rgb sobel edge magnitude block
// depends on sem_pkg, sem_ctrl and sem_datapath
`default_nettype none

// Usage: set frame_width (index 0) and frame_height (index 1) on the csr
// channel while idle; the geometry is sampled at the first pixel of a frame.
// Send pixels in raster order on req_ with tuser = 0, then flush requests
// with tuser = 1 until the result with rsp_tlast high has been delivered.
// Each result is one 3x3 sobel magnitude per color, borders taken as black.
// A pixel request without a result runs a line store read and a window shift;
// one with a result adds gradient, square, eight root steps of one bit each
// and rounding. The first pixel of a frame also runs geometry latch and multiply.
// A flush request runs a check, read and shift for each window shift needed,
// then the result steps. Requests are taken one at a time. After reset all
// MAX_WIDTH line store entries are cleared with req_tready low. A stalled
// receiver holds the result in the output register; the next request is
// still taken and the block waits only when its own result is due.
module sobel_edge_magnitude_rgb_top
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [23:0]             req_tdata,  // red, green, blue
   input  wire logic                    req_tuser,  // func
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [23:0]                  rsp_tdata,  // edge_red, edge_green, edge_blue
   output logic                         rsp_tlast,  // frame_end
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_pixel (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_pixel (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

[sv/sem_checker.sv]
// port level checks of the sobel edge block, bound to the top level
// depends on sem_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sem_checker
   import sem_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result stays offered
   `SEM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")
   // a stalled result keeps its payload
   `SEM_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")
   // no result is left over from before reset
   `SEM_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid, "result valid after reset")
   // a new result is loaded only while the request side is busy
   `SEM_ASSERT(a_load_busy, $rose(rsp_tvalid) |-> !$past(req_tready), "result loaded while idle")

endmodule

bind sobel_edge_magnitude_rgb_top sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[bench/sobel_edge_magnitude_rgb_top_tb.sv]
// self-checking bench for the rgb sobel edge magnitude block: frames of many
// sizes with flush and noise requests, checked against an in-bench predictor
// depends on sem_pkg and sobel_edge_magnitude_rgb_top
`default_nettype none

module sobel_edge_magnitude_rgb_top_tb;
   import sem_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int ROWS_MAX   = 2048;
   localparam int IDLE_LIMIT = 6000;

   typedef struct packed {
      logic       func;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_req_t;

   typedef struct packed {
      logic [7:0] mag_r;
      logic [7:0] mag_g;
      logic [7:0] mag_b;
      logic       last;
   } edge_px_t;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [23:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [23:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   sobel_edge_magnitude_rgb_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pixel_req_t pending_reqs[$];
   edge_px_t   expected_edges[$];
   pixel_req_t shown_req;
   int errors = 0;
   int results_seen = 0;
   int reqs_sent = 0;
   int frames_sent;

   // predictor state
   logic [23:0] upper_line[LINE_MAX] = '{default: '0};
   logic [23:0] lower_line[LINE_MAX] = '{default: '0};
   logic [23:0] win[3][3] = '{default: '{default: '0}};
   int unsigned cfg_width, cfg_height;
   int unsigned geo_w = 640;
   int unsigned geo_h = 480;
   int unsigned col_in = 0;
   int unsigned row_in = 0;
   int unsigned out_idx = 0;
   int unsigned arrived = 0;
   bit frame_in_done = 0;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] rounded_root(int unsigned s);
      int unsigned q;
      int unsigned t;
      q = 0;
      if (s >= 65281) return MAG_MAX;
      for (int b = 7; b >= 0; b--) begin
         t = q | (1 << b);
         if (t * t <= s) q = t;
      end
      if (s > q * q + q) q++;
      return q[7:0];
   endfunction

   // move the window one column and update the line stores
   function automatic void window_shift(logic [23:0] pix, bit is_px);
      int unsigned c;
      logic [23:0] top, mid;
      c = (col_in >= LINE_MAX) ? LINE_MAX - 1 : col_in;
      top = upper_line[c];
      mid = lower_line[c];
      if (is_px) begin
         upper_line[c] = mid;
         lower_line[c] = pix;
      end
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = is_px ? pix : 24'd0;
      arrived++;
      col_in++;
      if (col_in >= geo_w) begin
         col_in = 0;
         if (is_px) row_in++;
      end
   endfunction

   // sobel magnitude of the current window, borders black
   function automatic edge_px_t sobel_out();
      edge_px_t e;
      int r, c, p, gx, gy, rr, cc;
      logic [7:0] mag[3];
      r = out_idx / geo_w;
      c = out_idx % geo_w;
      for (int ch = 0; ch < 3; ch++) begin
         gx = 0;
         gy = 0;
         for (int i = 0; i < 3; i++) begin
            rr = r + i - 1;
            for (int j = 0; j < 3; j++) begin
               cc = c + j - 1;
               if (rr >= 0 && rr < int'(geo_h) && cc >= 0 && cc < int'(geo_w)) begin
                  p = (win[i][j] >> (16 - 8 * ch)) & 8'hff;
                  gx += (j - 1) * ((i == 1) ? 2 : 1) * p;
                  gy += (i - 1) * ((j == 1) ? 2 : 1) * p;
               end
            end
         end
         mag[ch] = rounded_root(gx * gx + gy * gy);
      end
      e.mag_r = mag[0];
      e.mag_g = mag[1];
      e.mag_b = mag[2];
      out_idx++;
      e.last = 1'b0;
      if (out_idx >= geo_w * geo_h) begin
         e.last = 1'b1;
         out_idx = 0;
         arrived = 0;
         col_in = 0;
         row_in = 0;
         frame_in_done = 0;
      end
      return e;
   endfunction

   // expected result of one accepted request
   function automatic void predict_edges(pixel_req_t q);
      int unsigned n;
      if (q.func == FUNC_PIXEL) begin
         if (frame_in_done) return;
         if (arrived == 0) begin
            geo_w = clamp_dim(cfg_width, LINE_MAX);
            geo_h = clamp_dim(cfg_height, ROWS_MAX);
            col_in = 0;
            row_in = 0;
            out_idx = 0;
         end
         n = arrived;
         window_shift({q.red, q.green, q.blue}, 1);
         if (arrived >= geo_w * geo_h) frame_in_done = 1;
         if (n >= geo_w + 1) expected_edges.push_back(sobel_out());
      end else begin
         if (!frame_in_done) return;
         while (arrived < out_idx + geo_w + 1) window_shift(24'd0, 0);
         window_shift(24'd0, 0);
         expected_edges.push_back(sobel_out());
      end
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // request driver: bursts and gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= 0;
         req_tuser <= 0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_edges(shown_req);
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
         end
         if (burst_left > 0 && pending_reqs.size() > 0) begin
            shown_req = pending_reqs.pop_front();
            req_tvalid <= 1;
            req_tuser <= shown_req.func;
            req_tdata <= {shown_req.blue, shown_req.green, shown_req.red};
            burst_left--;
            reqs_sent++;
         end else begin
            req_tvalid <= 0;
            if (burst_left == 0 && gap_left > 0) gap_left--;
         end
      end
   end

   // result monitor with its own stall pattern
   int stall_left, run_left, idle_cycles;
   edge_px_t want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         stall_left = 0;
         run_left = 0;
         idle_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_edges.size() == 0) begin
               $display("%0t: unexpected result %h last %b", $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_edges.pop_front();
               if (rsp_tdata[7:0] !== want.mag_r || rsp_tdata[15:8] !== want.mag_g ||
                   rsp_tdata[23:16] !== want.mag_b || rsp_tlast !== want.last) begin
                  $display("%0t: mismatch expected r %0d g %0d b %0d last %b, actual r %0d g %0d b %0d last %b",
                           $time, want.mag_r, want.mag_g, want.mag_b, want.last,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
                  errors++;
               end
            end
         end
         if (run_left > 0) begin
            run_left--;
            rsp_tready <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else begin
            run_left = $urandom_range(0, 40);
            stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            rsp_tready <= 1;
         end
         // watchdog on handshakes
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("sobel_edge_magnitude_rgb_top_tb failed");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_edges.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == REG_FRAME_WIDTH) cfg_width = val & 12'h7ff;
      else cfg_height = val & 12'hfff;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h);
      wait_idle();
      write_csr(REG_FRAME_WIDTH, w);
      write_csr(REG_FRAME_HEIGHT, h);
   endtask

   function automatic pixel_req_t make_px(int mode, int k);
      pixel_req_t q;
      q.func = FUNC_PIXEL;
      case (mode)
         0: begin
            q.red = $urandom;
            q.green = $urandom;
            q.blue = $urandom;
         end
         1: begin
            q.red = k[0] ? 8'hff : 8'h00;
            q.green = k[1] ? 8'hff : 8'h00;
            q.blue = k[0] ? 8'h00 : 8'hff;
         end
         default: begin
            q.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
            q.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            q.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
      endcase
      return q;
   endfunction

   // one whole frame plus its flushes, noise optional
   task automatic queue_frame(int unsigned w, int unsigned h, int mode, bit noisy);
      int unsigned gw, gh, total, flushes;
      pixel_req_t fl;
      gw = clamp_dim(w & 12'h7ff, LINE_MAX);
      gh = clamp_dim(h, ROWS_MAX);
      total = gw * gh;
      flushes = (total < gw + 1) ? total : gw + 1;
      fl = '0;
      fl.func = FUNC_FLUSH;
      for (int k = 0; k < total; k++) begin
         if (noisy && $urandom_range(0, 15) == 0) begin
            fl.red = $urandom;
            pending_reqs.push_back(fl);
         end
         pending_reqs.push_back(make_px(mode, k));
      end
      for (int k = 0; k < flushes; k++) begin
         // stray pixel while outputs still pending
         if (noisy && k == flushes - 1 && $urandom_range(0, 3) == 0)
            pending_reqs.push_back(make_px(0, k));
         pending_reqs.push_back(fl);
      end
      // flush after the frame has ended
      if (noisy && $urandom_range(0, 5) == 0) pending_reqs.push_back(fl);
      frames_sent++;
   endtask

   // stimulus
   initial begin
      pixel_req_t fl;
      int unsigned w, h;
      reset = 1;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      frames_sent = 0;
      cfg_width = 640;
      cfg_height = 480;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: early flush, extremes, degenerate and wider geometry
      set_geometry(3, 3);
      fl = '0;
      fl.func = FUNC_FLUSH;
      pending_reqs.push_back(fl);
      queue_frame(3, 3, 1, 0);
      queue_frame(3, 3, 2, 1);
      set_geometry(1, 1);
      queue_frame(1, 1, 0, 1);
      set_geometry(0, 0);
      queue_frame(0, 0, 2, 0);
      set_geometry(20, 3);
      queue_frame(20, 3, 0, 0);
      set_geometry(1, 12);
      queue_frame(1, 12, 2, 0);
      set_geometry(16, 1);
      queue_frame(16, 1, 1, 0);

      // random frames of small sizes
      while (reqs_sent < 450) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         set_geometry(w, h);
         repeat ($urandom_range(1, 3)) queue_frame(w, h, $urandom_range(0, 2), 1);
         if (reqs_sent > 900) break;
      end

      wait_idle();
      $display("covered %0d frames, %0d requests, %0d results checked",
               frames_sent, reqs_sent, results_seen);
      if (errors == 0)
         $display("sobel_edge_magnitude_rgb_top_tb passed");
      else
         $display("sobel_edge_magnitude_rgb_top_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
